// ===== hw/rtl/tfec_pkg.sv =====
// Package with codes, field widths and reset constants of the three-floor elevator controller.
package tfec_pkg;

    localparam int CAB_W     = 3;
    localparam int HALL_W    = 6;
    localparam int SENSOR_W  = 6;
    localparam int MOTOR_W   = 2;
    localparam int REQ_W     = 4;
    localparam int COUNT_W   = 16;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;

    localparam logic [COUNT_W-1:0] DOOR_WAIT_RESET = 16'd8000;

    typedef enum logic [MOTOR_W-1:0] {
        MOTOR_STOP = 2'd0,
        MOTOR_UP   = 2'd1,
        MOTOR_DOWN = 2'd2
    } motor_t;

    localparam int REQ_F1  = 0;
    localparam int REQ_F2U = 1;
    localparam int REQ_F2D = 2;
    localparam int REQ_F3  = 3;

    localparam int SENS_EMPTY   = 0;
    localparam int SENS_ALLOWED = 1;
    localparam int SENS_OVER    = 2;
    localparam int SENS_AT1     = 3;
    localparam int SENS_AT2     = 4;
    localparam int SENS_AT3     = 5;

    localparam int HALL_F1_UP   = 0;
    localparam int HALL_F1_DOWN = 1;
    localparam int HALL_F2_UP   = 2;
    localparam int HALL_F2_DOWN = 3;
    localparam int HALL_F3_UP   = 4;
    localparam int HALL_F3_DOWN = 5;

endpackage

// ===== hw/rtl/three_floor_elevator_controller_top.sv =====
// An accepted input item is held in the input register, and its result then goes to the result register.
// Throughput: one item per cycle while the result side takes items every cycle.
// The request, motor and wait-count state registers update together with the result register.
// Reset (aresetn, synchronous, active low) clears request flags, motor, wait count and valids,
// and loads the door wait limit with 8000.
module three_floor_elevator_controller_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [tfec_pkg::COUNT_W-1:0]    cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // cab_button_levels[2:0], hall_button_levels[8:3], sensor_levels[14:9], zero[15]
    input  logic [tfec_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // motor_drive[1:0], pending_requests[5:2], zero[7:6]
    output logic [tfec_pkg::M_TDATA_W-1:0]  m_tdata
);
    import tfec_pkg::*;

    logic                  in_valid_reg;
    logic [CAB_W-1:0]      cab_reg;
    logic [HALL_W-1:0]     hall_reg;
    logic [SENSOR_W-1:0]   sens_reg;

    logic                  out_valid_reg;
    logic [M_TDATA_W-1:0]  out_data_reg;
    logic [M_TDATA_W-1:0]  out_data_next;

    logic [COUNT_W-1:0]    door_wait_reg;
    logic [REQ_W-1:0]      req_reg;
    logic [REQ_W-1:0]      req_next;
    motor_t                drive_reg;
    motor_t                drive_next;
    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    count_next;

    logic                  advance;
    logic                  s_accept;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        logic [CAB_W-1:0]  cab;
        logic [HALL_W-1:0] hall;
        logic              at1;
        logic              at2;
        logic              at3;
        logic              up;
        logic              down;
        logic              gate;
        logic              hit;
        motor_t            target;

        cab  = ~cab_reg;
        hall = ~hall_reg;
        at1  = !sens_reg[SENS_AT1];
        at2  = !sens_reg[SENS_AT2];
        at3  = !sens_reg[SENS_AT3];
        up   = drive_reg[0];
        down = drive_reg[1];

        req_next   = req_reg;
        drive_next = drive_reg;
        count_next = count_reg;
        hit        = 1'b0;
        target     = MOTOR_STOP;

        if (cab[0] || hall[HALL_F1_UP] || hall[HALL_F1_DOWN]) begin
            req_next[REQ_F1] = 1'b1;
        end
        if (cab[1] || hall[HALL_F2_UP]) begin
            req_next[REQ_F2U] = 1'b1;
        end
        if (cab[1] || hall[HALL_F2_DOWN]) begin
            req_next[REQ_F2D] = 1'b1;
        end
        if (cab[2] || hall[HALL_F3_UP] || hall[HALL_F3_DOWN]) begin
            req_next[REQ_F3] = 1'b1;
        end
        if ((cab != '0) || (hall != '0)) begin
            count_next = '0;
        end

        if (req_next[REQ_F1] && at1 && !up) begin
            req_next[REQ_F1] = 1'b0;
            drive_next       = MOTOR_STOP;
        end else if (req_next[REQ_F2U] && at2 && !down) begin
            req_next[REQ_F2U] = 1'b0;
            req_next[REQ_F2D] = 1'b0;
            drive_next        = MOTOR_STOP;
        end else if (req_next[REQ_F2D] && at2 && !up) begin
            req_next[REQ_F2U] = 1'b0;
            req_next[REQ_F2D] = 1'b0;
            drive_next        = MOTOR_STOP;
        end else if (req_next[REQ_F3] && at3 && !down) begin
            req_next[REQ_F3] = 1'b0;
            drive_next       = MOTOR_STOP;
        end

        gate = (drive_next == MOTOR_STOP)
            && (sens_reg[SENS_EMPTY] || sens_reg[SENS_OVER])
            && !sens_reg[SENS_ALLOWED];

        if (gate) begin
            if (at1 && (req_next[REQ_F2U] || req_next[REQ_F2D] || req_next[REQ_F3])) begin
                hit    = 1'b1;
                target = MOTOR_UP;
            end else if (at2 && req_next[REQ_F3]) begin
                hit    = 1'b1;
                target = MOTOR_UP;
            end else if (at2 && req_next[REQ_F1]) begin
                hit    = 1'b1;
                target = MOTOR_DOWN;
            end else if (at3 && (req_next[REQ_F1] || req_next[REQ_F2U] || req_next[REQ_F2D])) begin
                hit    = 1'b1;
                target = MOTOR_DOWN;
            end
            if (hit) begin
                if (count_next < door_wait_reg) begin
                    count_next = count_next + COUNT_W'(1);
                end else begin
                    drive_next = target;
                end
            end
        end else begin
            count_next = '0;
        end

        out_data_next = {2'b00, req_next, drive_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            door_wait_reg <= DOOR_WAIT_RESET;
            req_reg       <= '0;
            drive_reg     <= MOTOR_STOP;
            count_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                door_wait_reg <= cfg_wr_data;
            end
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                req_reg       <= req_next;
                drive_reg     <= drive_next;
                count_reg     <= count_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cab_reg  <= s_tdata[CAB_W-1:0];
            hall_reg <= s_tdata[CAB_W+HALL_W-1:CAB_W];
            sens_reg <= s_tdata[CAB_W+HALL_W+SENSOR_W-1:CAB_W+HALL_W];
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    a_result_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (m_tdata[MOTOR_W-1:0] == drive_reg)
                 && (m_tdata[MOTOR_W+REQ_W-1:MOTOR_W] == req_reg))
        else $error("result item differs from updated state");

    a_start_after_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (drive_reg != MOTOR_STOP) && ($past(drive_reg) == MOTOR_STOP)
            |-> ($past(count_reg) >= $past(door_wait_reg)))
        else $error("motor started before the wait count reached its limit");

    a_hold_without_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(req_reg) && $stable(drive_reg) && $stable(count_reg))
        else $error("controller state changed without an item");

endmodule

// ===== tb/tb.sv =====
// Testbench for the three-floor elevator controller: car-ride stimulus, scoreboard, watchdog.
`timescale 1ns / 1ps

module tb;
    import tfec_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int RIDES_PER_PHASE = 170;

    localparam logic [2:0] NO_CAB     = 3'b111;
    localparam logic [5:0] NO_HALL    = 6'h3F;
    localparam logic [2:0] AT_NONE    = 3'b111;
    localparam logic [2:0] AT_FLOOR1  = 3'b110;
    localparam logic [2:0] AT_FLOOR2  = 3'b101;
    localparam logic [2:0] AT_FLOOR3  = 3'b011;
    localparam logic [2:0] LOAD_OK    = 3'b101;
    localparam logic [2:0] LOAD_EMPTY = 3'b100;
    localparam logic [2:0] LOAD_OVER  = 3'b001;

    class elevator_scoreboard;
        logic [REQ_W-1:0]   req_flags;
        motor_t             drive;
        logic [COUNT_W-1:0] wait_cnt;
        logic [COUNT_W-1:0] wait_limit;
        motor_t             motor_q[$];
        logic [REQ_W-1:0]   req_q[$];
        int                 errors;
        int                 checked;

        function new();
            req_flags  = '0;
            drive      = MOTOR_STOP;
            wait_cnt   = '0;
            wait_limit = DOOR_WAIT_RESET;
            errors     = 0;
            checked    = 0;
        endfunction

        function void set_limit(logic [COUNT_W-1:0] limit);
            wait_limit = limit;
        endfunction

        function int pending();
            return motor_q.size();
        endfunction

        function void count_or_start(motor_t dir);
            if (wait_cnt < wait_limit) begin
                wait_cnt = wait_cnt + 1'b1;
            end else begin
                drive = dir;
            end
        endfunction

        function void note_item(logic [CAB_W-1:0] cab_lv, logic [HALL_W-1:0] hall_lv,
                                logic [SENSOR_W-1:0] sens);
            logic [CAB_W-1:0]  cab;
            logic [HALL_W-1:0] hall;
            logic              at1, at2, at3, going_up, going_down;
            cab        = ~cab_lv;
            hall       = ~hall_lv;
            at1        = !sens[SENS_AT1];
            at2        = !sens[SENS_AT2];
            at3        = !sens[SENS_AT3];
            going_up   = drive[0];
            going_down = drive[1];

            if (cab[0] || hall[HALL_F1_UP] || hall[HALL_F1_DOWN]) req_flags[REQ_F1] = 1'b1;
            if (cab[1]) begin
                req_flags[REQ_F2U] = 1'b1;
                req_flags[REQ_F2D] = 1'b1;
            end
            if (hall[HALL_F2_UP]) req_flags[REQ_F2U] = 1'b1;
            if (hall[HALL_F2_DOWN]) req_flags[REQ_F2D] = 1'b1;
            if (cab[2] || hall[HALL_F3_UP] || hall[HALL_F3_DOWN]) req_flags[REQ_F3] = 1'b1;
            if (cab != '0 || hall != '0) wait_cnt = '0;

            if (req_flags[REQ_F1] && at1 && !going_up) begin
                req_flags[REQ_F1] = 1'b0;
                drive = MOTOR_STOP;
            end else if (req_flags[REQ_F2U] && at2 && !going_down) begin
                req_flags[REQ_F2U] = 1'b0;
                req_flags[REQ_F2D] = 1'b0;
                drive = MOTOR_STOP;
            end else if (req_flags[REQ_F2D] && at2 && !going_up) begin
                req_flags[REQ_F2U] = 1'b0;
                req_flags[REQ_F2D] = 1'b0;
                drive = MOTOR_STOP;
            end else if (req_flags[REQ_F3] && at3 && !going_down) begin
                req_flags[REQ_F3] = 1'b0;
                drive = MOTOR_STOP;
            end

            if (drive == MOTOR_STOP && (sens[SENS_EMPTY] || sens[SENS_OVER])
                    && !sens[SENS_ALLOWED]) begin
                if (at1 && (req_flags[REQ_F2U] || req_flags[REQ_F2D] || req_flags[REQ_F3]))
                    count_or_start(MOTOR_UP);
                else if (at2 && req_flags[REQ_F3])
                    count_or_start(MOTOR_UP);
                else if (at2 && req_flags[REQ_F1])
                    count_or_start(MOTOR_DOWN);
                else if (at3 && (req_flags[REQ_F1] || req_flags[REQ_F2U] || req_flags[REQ_F2D]))
                    count_or_start(MOTOR_DOWN);
            end else begin
                wait_cnt = '0;
            end

            motor_q.push_back(drive);
            req_q.push_back(req_flags);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data);
            motor_t           exp_motor;
            logic [REQ_W-1:0] exp_req;
            if (motor_q.size() == 0) begin
                $error("unexpected result item 0x%02h", data);
                errors++;
                return;
            end
            exp_motor = motor_q.pop_front();
            exp_req   = req_q.pop_front();
            checked++;
            if (data[1:0] != exp_motor) begin
                $error("motor_drive: expected %0d, actual %0d", exp_motor, data[1:0]);
                errors++;
            end
            if (data[5:2] != exp_req) begin
                $error("pending_requests: expected 0x%01h, actual 0x%01h", exp_req, data[5:2]);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [COUNT_W-1:0]   cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    elevator_scoreboard sb;
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_left;
    logic hold_req;
    logic hold_done;
    int stall_cycles;
    int items_sent;
    int settings_used;
    int car_pos;
    int travel_left;

    three_floor_elevator_controller_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_item(logic [S_TDATA_W-1:0] word);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_item(word[2:0], word[8:3], word[14:9]);
        items_sent++;
    endtask

    task automatic send_levels(logic [2:0] cab, logic [5:0] hall, logic [2:0] floors,
                               logic [2:0] load);
        send_item({1'b0, floors, load, hall, cab});
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_wait_limit(logic [COUNT_W-1:0] limit);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= limit;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_limit(limit);
        settings_used++;
    endtask

    // drive sensor pins from a simple car that follows the predicted motor command
    task automatic run_rides(int count);
        logic [2:0] cab;
        logic [5:0] hall;
        logic [2:0] floors;
        logic [2:0] load;
        int         roll;
        for (int n = 0; n < count; n++) begin
            if (sb.drive == MOTOR_UP && car_pos < 4) begin
                if (travel_left == 0) begin
                    car_pos++;
                    travel_left = $urandom_range(3);
                end else begin
                    travel_left--;
                end
            end else if (sb.drive == MOTOR_DOWN && car_pos > 0) begin
                if (travel_left == 0) begin
                    car_pos--;
                    travel_left = $urandom_range(3);
                end else begin
                    travel_left--;
                end
            end
            roll = $urandom_range(99);
            if (roll < 5) begin
                send_item({1'b0, 15'($urandom_range(16'h7FFF))});
            end else begin
                cab  = NO_CAB;
                hall = NO_HALL;
                if (roll < 17) cab[2'($urandom_range(2))] = 1'b0;
                else if (roll < 29) hall[3'($urandom_range(5))] = 1'b0;
                else if (roll < 32) begin
                    cab  = 3'($urandom_range(7));
                    hall = 6'($urandom_range(63));
                end
                case (car_pos)
                    0: floors = AT_FLOOR1;
                    2: floors = AT_FLOOR2;
                    4: floors = AT_FLOOR3;
                    default: floors = AT_NONE;
                endcase
                if ($urandom_range(99) < 8) floors = 3'($urandom_range(7));
                case ($urandom_range(2))
                    0: load = LOAD_OK;
                    1: load = LOAD_EMPTY;
                    default: load = LOAD_OVER;
                endcase
                if ($urandom_range(99) < 12) load = 3'($urandom_range(7));
                send_levels(cab, hall, floors, load);
            end
        end
    endtask

    initial begin
        sb          = new();
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        hold_req    = 1'b0;
        items_sent    = 0;
        settings_used = 0;
        car_pos       = 0;
        travel_left   = 0;
        tx_idle_pct   = 37;
        rx_idle_pct   = 77;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed items under the reset wait limit
        send_levels(NO_CAB, NO_HALL, AT_NONE, 3'b111);
        send_levels(3'b000, 6'h00, 3'b000, 3'b000);
        send_levels(NO_CAB, NO_HALL, AT_NONE, LOAD_OK);
        send_levels(3'b110, NO_HALL, AT_NONE, LOAD_OK);
        send_levels(3'b101, NO_HALL, AT_NONE, LOAD_OK);
        send_levels(3'b011, NO_HALL, AT_NONE, LOAD_OK);
        for (int b = 0; b < HALL_W; b++)
            send_levels(NO_CAB, ~(6'd1 << b), AT_NONE, LOAD_OK);
        send_levels(NO_CAB, NO_HALL, AT_FLOOR1, LOAD_OK);
        send_levels(NO_CAB, NO_HALL, AT_FLOOR2, LOAD_OK);
        send_levels(NO_CAB, NO_HALL, AT_FLOOR3, LOAD_OK);
        send_levels(NO_CAB, 6'b101111, AT_FLOOR1, LOAD_EMPTY);
        send_levels(NO_CAB, NO_HALL, AT_FLOOR1, LOAD_OVER);
        send_levels(NO_CAB, NO_HALL, AT_FLOOR1, 3'b000);
        send_levels(NO_CAB, NO_HALL, AT_FLOOR1, 3'b010);
        send_levels(NO_CAB, NO_HALL, AT_FLOOR1, 3'b111);
        send_levels(3'b010, NO_HALL, 3'b000, LOAD_OK);
        send_levels(NO_CAB, NO_HALL, 3'b100, LOAD_OK);
        send_levels(3'b000, NO_HALL, AT_NONE, 3'b111);
        drain_results();

        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 2) begin
                tx_idle_pct = 77;
                rx_idle_pct = 37;
            end else if (phase == 4) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (phase)
                0: write_wait_limit(16'd0);
                1: begin
                    // build up a count under the top limit, then lower the limit below it
                    write_wait_limit(16'hFFFF);
                    send_levels(3'b011, NO_HALL, AT_NONE, LOAD_OK);
                    repeat (20) send_levels(NO_CAB, NO_HALL, AT_FLOOR1, LOAD_OK);
                    drain_results();
                    write_wait_limit(16'd2);
                    send_levels(NO_CAB, NO_HALL, AT_FLOOR1, LOAD_OK);
                    car_pos     = 0;
                    travel_left = 0;
                end
                2: write_wait_limit(16'd3);
                3: write_wait_limit(16'($urandom_range(15, 1)));
                4: begin
                    write_wait_limit(16'd1);
                    hold_req <= 1'b1;
                end
                default: write_wait_limit(16'($urandom_range(8)));
            endcase
            run_rides(RIDES_PER_PHASE);
            drain_results();
        end
        repeat (10) @(posedge aclk);

        $display("tb: %0d items sent, %0d results checked, %0d wait limit settings",
                 items_sent, sb.checked, settings_used);
        $display("tb: covered directed pins, car rides with idle, stall and backpressure mixes");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/tfec_pkg.sv
hw/rtl/three_floor_elevator_controller_top.sv
tb/tb.sv
